// File: src/buddy_block_allocator_defines.svh
// Assertion macros for the buddy block allocator checker.
// No dependencies; included by files that assert.
`ifndef BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define BBA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bba check failed");

// next-cycle implication
`define BBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bba check failed");

`endif

// File: src/bba_pkg.sv
// Types and constants shared by the buddy block allocator modules.
// No dependencies.
`default_nettype none

package bba_pkg;

   localparam int ORD_W    = 5;
   localparam int SIZE_W   = 17;
   localparam int OFF_W    = 16;
   localparam logic [ORD_W-1:0] POOL_ORDER_RESET = 5'd16;

   typedef enum logic {
      MODE_ALLOC = 1'b0,
      MODE_FREE  = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK         = 2'd0,
      STAT_NO_SPACE   = 2'd1,
      STAT_TOO_LARGE  = 2'd2,
      STAT_BAD_OFFSET = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      NODE_ABSENT = 2'd0,
      NODE_FREE   = 2'd1,
      NODE_ALLOC  = 2'd2,
      NODE_SPLIT  = 2'd3
   } node_code_type;

   typedef struct packed {
      mode_type          mode;
      logic [SIZE_W-1:0] request_size;
      logic [OFF_W-1:0]  block_offset;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [OFF_W-1:0]  granted_offset;
      logic [ORD_W-1:0]  granted_order;
   } rsp_type;

   typedef enum logic [2:0] {
      NOP_HOLD,
      NOP_ROOT,
      NOP_ORD_INIT,
      NOP_ORD_NEXT,
      NOP_NEXT,
      NOP_LEFT,
      NOP_DESCEND,
      NOP_UP
   } node_op_type;

   typedef enum logic [2:0] {
      SEL_NODE,
      SEL_LEFT,
      SEL_RIGHT,
      SEL_SIBLING,
      SEL_CLEAR
   } addr_sel_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_AL_RD,
      S_AL_CHK,
      S_SP_W0,
      S_SP_W1,
      S_SP_W2,
      S_SP_TEST,
      S_FR_RD,
      S_FR_CHK,
      S_MG_TEST,
      S_MG_CHK,
      S_MG_W1,
      S_MG_W2
   } state_type;

   typedef struct packed {
      logic          load;
      logic          clr_step;
      node_op_type   node_op;
      logic          rd_en;
      addr_sel_type  rd_sel;
      logic          wr_en;
      addr_sel_type  wr_sel;
      node_code_type wr_code;
      logic          emit;
      status_type    emit_status;
   } bba_cmd_type;

   typedef struct packed {
      logic          free_mode;
      logic          too_large;
      logic          out_of_range;
      node_code_type rd_code;
      logic          last_node;
      logic          top_order;
      logic          split_done;
      logic          can_descend;
      logic          offset_match;
      logic          at_root;
      logic          clr_done;
   } bba_stat_type;

endpackage

`default_nettype wire

// File: src/buddy_block_allocator.sv
// Top level of the buddy block allocator: controller plus datapath.
// Depends on bba_pkg, bba_ctrl, bba_dpath.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------
//  request  | start / busy           | req_item (mode, size, offset)
//  response | rsp_valid strobe       | rsp_item (status, offset, order)
//  config   | csr_valid / csr_ready  | csr_data (pool order)
//
// Allocate scans the tree level by level from the rounded request order up,
// then splits down to that order; the single read port of the node store sets the pace.
// Free descends from the root to the block, then merges free buddies upward.
// Items rejected for size or offset range are answered at decode.
// After reset and after every config write a clearing pass over the node
// store runs with busy high.
// Each result strobes for one cycle; the receiver cannot stall it.
`default_nettype none

module buddy_block_allocator #(
   parameter int POOL_ORDER = 16,
   parameter int MIN_ORDER  = 4
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output      logic                      busy,
   input  wire bba_pkg::req_type          req_item,
   output      logic                      rsp_valid,
   output      bba_pkg::rsp_type          rsp_item,
   input  wire logic                      csr_valid,
   output      logic                      csr_ready,
   input  wire logic [bba_pkg::ORD_W-1:0] csr_data
);
   import bba_pkg::*;

   bba_cmd_type  cmd;
   bba_stat_type stat;
   logic         csr_we;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid & csr_ready;

   bba_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .csr_we (csr_we),
      .stat   (stat),
      .cmd    (cmd),
      .busy   (busy)
   );

   bba_dpath #(
      .POOL_ORDER (POOL_ORDER),
      .MIN_ORDER  (MIN_ORDER)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .csr_we    (csr_we),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire

// File: src/bba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bba_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 8192
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: src/bba_ctrl.sv
// Controller state machine for the buddy block allocator.
// Depends on bba_pkg; drives bba_dpath through a command struct.
`default_nettype none

module bba_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic                  csr_we,
   input  wire bba_pkg::bba_stat_type stat,
   output      bba_pkg::bba_cmd_type  cmd,
   output      logic                  busy
);
   import bba_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            cmd.wr_en    = 1'b1;
            cmd.wr_sel   = SEL_CLEAR;
            if (stat.clr_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.free_mode) begin
               if (stat.out_of_range) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_status = STAT_BAD_OFFSET;
                  state_in        = S_IDLE;
               end else begin
                  cmd.node_op = NOP_ROOT;
                  state_in    = S_FR_RD;
               end
            end else if (stat.too_large) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = STAT_TOO_LARGE;
               state_in        = S_IDLE;
            end else begin
               cmd.node_op = NOP_ORD_INIT;
               state_in    = S_AL_RD;
            end
         end
         S_AL_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = SEL_NODE;
            state_in   = S_AL_CHK;
         end
         S_AL_CHK: begin
            if (stat.rd_code == NODE_FREE) begin
               state_in = S_SP_TEST;
            end else if (!stat.last_node) begin
               cmd.node_op = NOP_NEXT;
               state_in    = S_AL_RD;
            end else if (!stat.top_order) begin
               cmd.node_op = NOP_ORD_NEXT;
               state_in    = S_AL_RD;
            end else begin
               cmd.emit        = 1'b1;
               cmd.emit_status = STAT_NO_SPACE;
               state_in        = S_IDLE;
            end
         end
         S_SP_TEST: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = SEL_NODE;
            if (stat.split_done) begin
               cmd.wr_code     = NODE_ALLOC;
               cmd.emit        = 1'b1;
               cmd.emit_status = STAT_OK;
               state_in        = S_IDLE;
            end else begin
               cmd.wr_code = NODE_SPLIT;
               state_in    = S_SP_W1;
            end
         end
         S_SP_W0: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = SEL_NODE;
            cmd.wr_code = NODE_SPLIT;
            state_in    = S_SP_W1;
         end
         S_SP_W1: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = SEL_LEFT;
            cmd.wr_code = NODE_FREE;
            state_in    = S_SP_W2;
         end
         S_SP_W2: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = SEL_RIGHT;
            cmd.wr_code = NODE_FREE;
            cmd.node_op = NOP_LEFT;
            state_in    = S_SP_TEST;
         end
         S_FR_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = SEL_NODE;
            state_in   = S_FR_CHK;
         end
         S_FR_CHK: begin
            if (stat.rd_code == NODE_SPLIT && stat.can_descend) begin
               cmd.node_op = NOP_DESCEND;
               state_in    = S_FR_RD;
            end else if (stat.rd_code == NODE_ALLOC && stat.offset_match) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_sel  = SEL_NODE;
               cmd.wr_code = NODE_FREE;
               state_in    = S_MG_TEST;
            end else begin
               cmd.emit        = 1'b1;
               cmd.emit_status = STAT_BAD_OFFSET;
               state_in        = S_IDLE;
            end
         end
         S_MG_TEST: begin
            if (stat.at_root) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = STAT_OK;
               state_in        = S_IDLE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = SEL_SIBLING;
               state_in   = S_MG_CHK;
            end
         end
         S_MG_CHK: begin
            if (stat.rd_code == NODE_FREE) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_sel  = SEL_NODE;
               cmd.wr_code = NODE_ABSENT;
               state_in    = S_MG_W1;
            end else begin
               cmd.emit        = 1'b1;
               cmd.emit_status = STAT_OK;
               state_in        = S_IDLE;
            end
         end
         S_MG_W1: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = SEL_SIBLING;
            cmd.wr_code = NODE_ABSENT;
            cmd.node_op = NOP_UP;
            state_in    = S_MG_W2;
         end
         S_MG_W2: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = SEL_NODE;
            cmd.wr_code = NODE_FREE;
            state_in    = S_MG_TEST;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
      // a register write restarts the clearing pass
      if (csr_we) begin
         state_in = S_CLEAR;
         cmd.load = 1'b0;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

`default_nettype wire

// File: src/bba_dpath.sv
// Datapath of the buddy block allocator: node tree store, walk registers,
// pool order register and result register. Depends on bba_pkg and bba_ram.
`default_nettype none

module bba_dpath #(
   parameter int POOL_ORDER = 16,
   parameter int MIN_ORDER  = 4
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire bba_pkg::req_type            req_item,
   input  wire logic                        csr_we,
   input  wire logic [bba_pkg::ORD_W-1:0]   csr_data,
   input  wire bba_pkg::bba_cmd_type        cmd,
   output      bba_pkg::bba_stat_type       stat,
   output      logic                        rsp_valid,
   output      bba_pkg::rsp_type            rsp_item
);
   import bba_pkg::*;

   localparam int NW    = POOL_ORDER - MIN_ORDER + 1;
   localparam int NODES = 1 << NW;
   localparam int OW    = (POOL_ORDER + 1 > 17) ? POOL_ORDER + 1 : 17;
   localparam logic [ORD_W-1:0] MIN_O  = ORD_W'(MIN_ORDER);
   localparam logic [ORD_W-1:0] POOL_O = ORD_W'(POOL_ORDER);

   req_type          req_ff;
   logic [ORD_W-1:0] pool_ff;
   logic [NW-1:0]    n_ff, n_in;
   logic [ORD_W-1:0] d_ff, d_in;
   logic [ORD_W-1:0] ord_ff, ord_in;
   logic [NW-1:0]    clr_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;

   logic [ORD_W-1:0]  top;
   logic [ORD_W-1:0]  k;
   logic [ORD_W-1:0]  k_raw;
   logic [SIZE_W-1:0] size_m1;
   logic [NW-1:0]     lvl_first;
   logic [OW-1:0]     node_off;
   logic [OW-1:0]     off_ext;
   logic              off_bit;
   logic [NW-1:0]     rd_addr, wr_addr;
   logic [1:0]        wr_data;
   logic [1:0]        rd_data;

   function automatic logic [NW-1:0] sel_addr(addr_sel_type sel, logic [NW-1:0] n,
                                              logic [NW-1:0] c);
      logic [NW-1:0] a;
      unique case (sel)
         SEL_NODE:    a = n;
         SEL_LEFT:    a = n << 1;
         SEL_RIGHT:   a = (n << 1) | NW'(1);
         SEL_SIBLING: a = n ^ NW'(1);
         SEL_CLEAR:   a = c;
         default:     a = n;
      endcase
      return a;
   endfunction

   // live pool order, saturated to the supported range
   always_comb begin
      if (pool_ff < MIN_O) begin
         top = MIN_O;
      end else if (pool_ff > POOL_O) begin
         top = POOL_O;
      end else begin
         top = pool_ff;
      end
   end

   // rounded order of the request
   always_comb begin
      size_m1 = req_ff.request_size - SIZE_W'(1);
      k_raw   = '0;
      if (req_ff.request_size > SIZE_W'(1)) begin
         for (int b = 0; b < SIZE_W; b++) begin
            if (size_m1[b]) begin
               k_raw = ORD_W'(b + 1);
            end
         end
      end
      k = (k_raw < MIN_O) ? MIN_O : k_raw;
   end

   assign lvl_first = NW'(1) << d_ff;
   assign node_off  = OW'(n_ff - lvl_first) << (top - d_ff);
   assign off_ext   = OW'(req_ff.block_offset);
   assign off_bit   = off_ext[top - d_ff - ORD_W'(1)];

   always_comb begin
      n_in   = n_ff;
      d_in   = d_ff;
      ord_in = ord_ff;
      unique case (cmd.node_op)
         NOP_HOLD: begin
         end
         NOP_ROOT: begin
            n_in = NW'(1);
            d_in = '0;
         end
         NOP_ORD_INIT: begin
            ord_in = k;
            d_in   = top - k;
            n_in   = NW'(1) << (top - k);
         end
         NOP_ORD_NEXT: begin
            ord_in = ord_ff + ORD_W'(1);
            d_in   = d_ff - ORD_W'(1);
            n_in   = NW'(1) << (d_ff - ORD_W'(1));
         end
         NOP_NEXT: begin
            n_in = n_ff + NW'(1);
         end
         NOP_LEFT: begin
            n_in = n_ff << 1;
            d_in = d_ff + ORD_W'(1);
         end
         NOP_DESCEND: begin
            n_in = (n_ff << 1) | NW'(off_bit);
            d_in = d_ff + ORD_W'(1);
         end
         NOP_UP: begin
            n_in = n_ff >> 1;
            d_in = d_ff - ORD_W'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      d_ff   <= d_in;
      ord_ff <= ord_in;
      if (cmd.load) begin
         req_ff <= req_item;
      end
      if (cmd.emit) begin
         rsp_ff.status <= cmd.emit_status;
         if (cmd.emit_status == STAT_OK) begin
            rsp_ff.granted_offset <= node_off[OFF_W-1:0];
            rsp_ff.granted_order  <= (req_ff.mode == MODE_FREE) ? top - d_ff : k;
         end else begin
            rsp_ff.granted_offset <= '0;
            rsp_ff.granted_order  <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_ff      <= POOL_ORDER_RESET;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
         if (csr_we) begin
            pool_ff <= csr_data;
            clr_ff  <= '0;
         end else if (cmd.clr_step) begin
            clr_ff <= clr_ff + NW'(1);
         end
      end
   end

   assign rd_addr = sel_addr(cmd.rd_sel, n_ff, clr_ff);
   assign wr_addr = sel_addr(cmd.wr_sel, n_ff, clr_ff);
   assign wr_data = (cmd.wr_sel == SEL_CLEAR) ?
                    ((clr_ff == NW'(1)) ? NODE_FREE : NODE_ABSENT) : cmd.wr_code;

   bba_ram #(
      .WIDTH (2),
      .DEPTH (NODES)
   ) u_tree (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      stat.free_mode    = (req_ff.mode == MODE_FREE);
      stat.too_large    = (k > top);
      stat.out_of_range = (off_ext >= (OW'(1) << top));
      stat.rd_code      = node_code_type'(rd_data);
      stat.last_node    = (n_ff == NW'((lvl_first << 1) - NW'(1)));
      stat.top_order    = (ord_ff == top);
      stat.split_done   = (d_ff == top - k);
      stat.can_descend  = (d_ff < top - MIN_O);
      stat.offset_match = (node_off == off_ext);
      stat.at_root      = (n_ff == NW'(1));
      stat.clr_done     = &clr_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

`default_nettype wire

// File: src/bba_checker.sv
// Port-level checks for the buddy block allocator, bound to the top level.
// Depends on bba_pkg and buddy_block_allocator_defines.svh.
`default_nettype none
`include "buddy_block_allocator_defines.svh"

module bba_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      start,
   input wire logic                      busy,
   input wire bba_pkg::req_type          req_item,
   input wire logic                      rsp_valid,
   input wire bba_pkg::rsp_type          rsp_item,
   input wire logic                      csr_valid,
   input wire logic                      csr_ready,
   input wire logic [bba_pkg::ORD_W-1:0] csr_data
);
   import bba_pkg::*;

   logic req_seen;
   logic csr_seen;
   logic err_rsp;
   logic err_zero;

   assign req_seen = start && !busy && req_item == req_item;
   assign csr_seen = csr_valid && csr_ready && csr_data == csr_data;
   assign err_rsp  = rsp_valid && rsp_item.status != STAT_OK;
   assign err_zero = rsp_item.granted_offset == '0 && rsp_item.granted_order == '0;

   `BBA_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid)
   `BBA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_seen, busy)
   `BBA_ASSERT_NEXT(a_clear_after_csr, clock, reset, csr_seen, busy)
   `BBA_ASSERT_SAME(a_error_zero, clock, reset, err_rsp, err_zero)

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (.*);

`default_nettype wire

// File: sim/tb_buddy_block_allocator.sv
// Self-checking testbench for buddy_block_allocator: directed and random
// allocate/free items over several pool sizes, checked against a tree model.
// Depends on bba_pkg and the allocator RTL.
`timescale 1ns / 100ps
`default_nettype none

module tb_buddy_block_allocator;
   import bba_pkg::*;

   localparam int TOP_ORDER = 16;
   localparam int MIN_ORD   = 4;
   localparam int NODES     = 1 << (TOP_ORDER - MIN_ORD + 1);

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   req_type             req_item = '0;
   logic                rsp_valid;
   rsp_type             rsp_item;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [ORD_W-1:0]    csr_data = '0;

   node_code_type       tree [NODES];
   int                  pool_setting;
   rsp_type             pending_rsp [$];
   int                  live_blocks [$];
   int                  fail_count = 0;
   bit                  gaps_on = 1'b1;

   buddy_block_allocator dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #300_000_000;
      $display("Verification failed");
      $finish;
   end

   function automatic int pool_top();
      int p;
      p = pool_setting;
      if (p < MIN_ORD) p = MIN_ORD;
      if (p > TOP_ORDER) p = TOP_ORDER;
      return p;
   endfunction

   function automatic void pool_wipe();
      foreach (tree[i]) tree[i] = NODE_ABSENT;
      tree[1] = NODE_FREE;
      live_blocks.delete();
   endfunction

   function automatic int node_base(int n, int d, int top);
      return (n - (1 << d)) << (top - d);
   endfunction

   // allocate or free against the tree copy; returns the expected response
   function automatic rsp_type alloc_free_step(req_type r);
      rsp_type o;
      int      top, k, n, d, dd, bit_sel, off;
      bit      found;
      longint  size;
      o = '0;
      o.status = STAT_OK;
      top = pool_top();
      found = 1'b0;
      if (r.mode == MODE_ALLOC) begin
         size = r.request_size;
         k = 0;
         while (k < 31 && (64'd1 << k) < size) k++;
         if (k < MIN_ORD) k = MIN_ORD;
         if (k > top) begin
            o.status = STAT_TOO_LARGE;
            return o;
         end
         for (int ord = k; ord <= top; ord++) begin
            d = top - ord;
            for (int i = 1 << d; i <= (1 << (d + 1)) - 1; i++) begin
               if (!found && tree[i] == NODE_FREE) begin
                  n = i;
                  dd = d;
                  while (dd < top - k) begin
                     tree[n] = NODE_SPLIT;
                     tree[2*n] = NODE_FREE;
                     tree[2*n+1] = NODE_FREE;
                     n = 2 * n;
                     dd++;
                  end
                  tree[n] = NODE_ALLOC;
                  o.granted_offset = OFF_W'(node_base(n, dd, top));
                  o.granted_order = ORD_W'(k);
                  live_blocks.push_back(node_base(n, dd, top));
                  found = 1'b1;
               end
            end
         end
         if (!found) o.status = STAT_NO_SPACE;
         return o;
      end
      off = r.block_offset;
      if (off >= (1 << top)) begin
         o.status = STAT_BAD_OFFSET;
         return o;
      end
      n = 1;
      d = 0;
      while (tree[n] == NODE_SPLIT && d < top - MIN_ORD) begin
         bit_sel = (off >> (top - d - 1)) & 1;
         n = 2 * n + bit_sel;
         d++;
      end
      if (tree[n] != NODE_ALLOC || node_base(n, d, top) != off) begin
         o.status = STAT_BAD_OFFSET;
         return o;
      end
      foreach (live_blocks[i])
         if (live_blocks[i] == off) found = 1'b1;
      if (found)
         foreach (live_blocks[i])
            if (live_blocks[i] == off) begin
               live_blocks.delete(i);
               break;
            end
      tree[n] = NODE_FREE;
      while (n > 1 && tree[n ^ 1] == NODE_FREE) begin
         tree[n] = NODE_ABSENT;
         tree[n ^ 1] = NODE_ABSENT;
         n = n >> 1;
         d--;
         tree[n] = NODE_FREE;
      end
      o.granted_offset = OFF_W'(node_base(n, d, top));
      o.granted_order = ORD_W'(top - d);
      return o;
   endfunction

   // response checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected response %p", rsp_item);
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_item.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_item.status);
               fail_count++;
            end
            if (rsp_item.granted_offset !== want.granted_offset) begin
               $error("granted_offset: expected %0d, got %0d",
                      want.granted_offset, rsp_item.granted_offset);
               fail_count++;
            end
            if (rsp_item.granted_order !== want.granted_order) begin
               $error("granted_order: expected %0d, got %0d",
                      want.granted_order, rsp_item.granted_order);
               fail_count++;
            end
         end
      end
   end

   task automatic send_item(mode_type m, int size, int off);
      int gap;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 16);
         @(negedge clock);
         start = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_item.mode = m;
      req_item.request_size = SIZE_W'(size);
      req_item.block_offset = OFF_W'(off);
      start = 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_rsp.push_back(alloc_free_step(req_item));
   endtask

   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_pool_order(int value);
      drain();
      @(negedge clock);
      csr_data = ORD_W'(value);
      csr_valid = 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      pool_setting = value;
      pool_wipe();
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // mostly well-formed traffic: frees of live blocks, allocs sized to the pool
   task automatic random_item();
      int top, pick, sz;
      top = pool_top();
      pick = $urandom_range(0, 9);
      if (pick < 4 && live_blocks.size() != 0)
         send_item(MODE_FREE, $urandom_range(0, (1 << SIZE_W) - 1),
                   live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
      else if (pick == 4)
         send_item(MODE_FREE, $urandom, $urandom_range(0, 65535));
      else if (pick == 5)
         send_item(MODE_ALLOC, $urandom_range(0, (1 << SIZE_W) - 1), $urandom);
      else begin
         sz = $urandom_range(0, top - MIN_ORD);
         sz = $urandom_range(0, 1 << (top - sz));
         send_item(MODE_ALLOC, sz, $urandom_range(0, 65535));
      end
   endtask

   task automatic test_directed();
      write_pool_order(MIN_ORD);
      send_item(MODE_ALLOC, 0, 0);
      send_item(MODE_ALLOC, 1, 0);          // pool exhausted
      send_item(MODE_FREE, 0, 16);          // outside pool
      send_item(MODE_FREE, 0, 0);
      send_item(MODE_FREE, 0, 0);           // already free
      send_item(MODE_ALLOC, 17, 0);         // too large
      write_pool_order(8);
      send_item(MODE_ALLOC, 16, 0);
      send_item(MODE_ALLOC, 16, 0);
      send_item(MODE_ALLOC, 32, 0);
      send_item(MODE_ALLOC, 100, 0);
      send_item(MODE_FREE, 0, 8);           // inside a block, not its start
      send_item(MODE_FREE, 0, 16);
      send_item(MODE_FREE, 0, 0);
      send_item(MODE_FREE, 0, 32);
      send_item(MODE_FREE, 0, 128);
      send_item(MODE_ALLOC, 256, 0);
      send_item(MODE_ALLOC, 65536, 0);
      send_item(MODE_ALLOC, (1 << SIZE_W) - 1, 0);
      write_pool_order(0);                  // saturates up to the minimum
      send_item(MODE_ALLOC, 16, 0);
      write_pool_order(31);                 // saturates down to the maximum
      send_item(MODE_ALLOC, 65536, 16'hFFFF);
      send_item(MODE_FREE, 0, 0);
      send_item(MODE_FREE, 0, 16'hFFFF);
      drain();
   endtask

   task automatic test_random_small();
      int orders [6] = '{5, 6, 7, 8, 9, 10};
      foreach (orders[i]) begin
         write_pool_order(orders[i]);
         repeat (240) random_item();
      end
      drain();
   endtask

   task automatic test_pause();
      write_pool_order(7);
      repeat (10) begin
         repeat ($urandom_range(1, 8)) random_item();
         drain();
      end
   endtask

   task automatic test_large_pool();
      write_pool_order(TOP_ORDER);
      repeat (25) begin
         if ($urandom_range(0, 3) == 0) random_item();
         else send_item(MODE_ALLOC, $urandom_range(2048, 65536), 0);
      end
      drain();
   endtask

   task automatic test_no_gaps();
      gaps_on = 1'b0;
      write_pool_order(6);
      repeat (150) random_item();
      drain();
   endtask

   initial begin
      pool_setting = POOL_ORDER_RESET;
      pool_wipe();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random_small();
      test_pause();
      test_large_pool();
      test_no_gaps();
      if (fail_count == 0 && pending_rsp.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire
